### hw/rtl/bbc_pkg.sv
// Shared types for the block buffer cache controller: operation, reply and sequencer codes.
`default_nettype none

package bbc_pkg;

  typedef enum logic [2:0] {
    OP_GET     = 3'd0,
    OP_READ    = 3'd1,
    OP_RELEASE = 3'd2,
    OP_DWRITE  = 3'd3,
    OP_WRITE   = 3'd4,
    OP_FLUSH   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    RK_DISK_WRITE = 2'd0,
    RK_DISK_READ  = 2'd1,
    RK_DONE       = 2'd2,
    RK_BUSY       = 2'd3
  } reply_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_BUSY,
    ST_VRD,
    ST_WB,
    ST_FILL,
    ST_RDCHK,
    ST_DONE,
    ST_HB,
    ST_HTAG,
    ST_HDONE,
    ST_FL_CHK,
    ST_FL_WB,
    ST_ONE
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/bbc_tag_ram.sv
// Tag store: one write port, one read port with registered read data.
`default_nettype none

module bbc_tag_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/block_buffer_cache_controller.sv
// Block buffer cache controller top level: lookup sequencer, entry flags, list order, output.
// Sequence: a get/read miss scans the list and decides, then runs fill, read check (carries
//   any disk read) and reply, with a tag read and a write-back first for a dirty victim.
//   A hit stops the scan early and skips the fill.
// Release, delayed write and write hand an entry back; flush walks the list and writes back
//   each dirty entry. One transaction in flight; input ready again once back in idle.
// Reset: all flags clear, list order ENTRIES-1 down to 0; tag RAM is not cleared.
`default_nettype none

module block_buffer_cache_controller #(
  parameter int ENTRIES    = 16,
  parameter int BLOCK_BITS = 24
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // request transaction
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [2:0]                operation_i,
  input  wire logic [23:0]               block_number_i,
  input  wire logic [3:0]                buffer_index_i,
  // result transaction
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output bbc_pkg::reply_kind_e           reply_kind_o,
  output logic [3:0]                     entry_index_o,
  output logic [23:0]                    disk_block_o,
  output logic                           was_hit_o,
  output logic                           last_o
);

  import bbc_pkg::*;

  // Entry index and list-walk counter widths; tags keep at most 24 bits.
  localparam int IdxW = $clog2(ENTRIES);
  localparam int CntW = IdxW + 1;
  localparam int TagW = (BLOCK_BITS < 24) ? BLOCK_BITS : 24;
  localparam logic [CntW-1:0] NumEnt = CntW'(ENTRIES);

  state_e state_q, state_d;

  // Per-entry flags and list order (head at slot 0).
  logic [ENTRIES-1:0] valid_q, busy_q, done_q, dirty_q;
  logic [IdxW-1:0]    list_q [ENTRIES];

  // Operation held for the length of the transaction.
  op_e             op_q;
  logic [TagW-1:0] blk_q;
  logic [3:0]      bi4_q;
  logic [IdxW-1:0] bi_idx;
  logic            bi_oor;

  // Scan and flush walk.
  logic [CntW-1:0] pos_q, step_q, fpos_q;
  logic            cmp_vld_q, hit_found_q, vic_found_q;
  logic [IdxW-1:0] cmp_ent_q, vic_q, ent_q;
  logic            hit_now;
  logic [IdxW-1:0] fl_ent;
  logic            fl_dirty;
  logic            need_rd;

  // Tag RAM port.
  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr;
  logic [TagW-1:0] tag_rdata;

  // Result staging.
  logic            can_emit;
  logic            em_vld, em_hit, em_last;
  reply_kind_e     em_kind;
  logic [3:0]      em_idx;
  logic [TagW-1:0] em_blk;

  // Flag update strobes.
  logic a_claim, a_fill, a_mark_done, a_handback, a_flush;

  logic            out_valid_q, hit_oq, last_oq;
  reply_kind_e     kind_oq;
  logic [3:0]      eidx_oq;
  logic [23:0]     dblk_oq;

  bbc_tag_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (TagW)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (tag_rdata),
    .wr_en_i   (wr_en),
    .wr_addr_i (ent_q),
    .wr_data_i (blk_q)
  );

  assign can_emit = !out_valid_q || out_ready_i;
  assign bi_idx   = IdxW'(bi4_q);
  assign bi_oor   = {28'd0, bi4_q} >= 32'(ENTRIES);
  // Compare stage of the scan: the tag read issued last cycle is now on the RAM output.
  assign hit_now  = (state_q == ST_SCAN) && cmp_vld_q && valid_q[cmp_ent_q] &&
                    (tag_rdata == blk_q);
  assign fl_ent   = list_q[fpos_q[IdxW-1:0]];
  assign fl_dirty = valid_q[fl_ent] && dirty_q[fl_ent];
  assign need_rd  = (op_q == OP_READ) && !done_q[ent_q];

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(operation_i))
            OP_GET, OP_READ:                  state_d = ST_SCAN;
            OP_RELEASE, OP_DWRITE, OP_WRITE:  state_d = ST_HB;
            OP_FLUSH:                         state_d = ST_FL_CHK;
            default:                          state_d = ST_ONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit_now || pos_q == NumEnt) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (hit_found_q) begin
          state_d = busy_q[ent_q] ? ST_BUSY : ST_RDCHK;
        end else if (!vic_found_q) begin
          state_d = ST_BUSY;
        end else if (valid_q[ent_q] && dirty_q[ent_q]) begin
          state_d = ST_VRD;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_BUSY:  if (can_emit) state_d = ST_IDLE;
      ST_VRD:   state_d = ST_WB;
      ST_WB:    if (can_emit) state_d = ST_FILL;
      ST_FILL:  state_d = ST_RDCHK;
      ST_RDCHK: if (!need_rd || can_emit) state_d = ST_DONE;
      ST_DONE:  if (can_emit) state_d = ST_IDLE;
      ST_HB: begin
        if (bi_oor) begin
          state_d = ST_ONE;
        end else if (valid_q[bi_idx]) begin
          state_d = ST_HTAG;
        end else begin
          state_d = ST_HDONE;
        end
      end
      ST_HTAG:  if (op_q != OP_WRITE || can_emit) state_d = ST_HDONE;
      ST_HDONE: if (can_emit) state_d = ST_IDLE;
      ST_FL_CHK: begin
        if (step_q == NumEnt) begin
          state_d = ST_ONE;
        end else if (fl_dirty) begin
          state_d = ST_FL_WB;
        end
      end
      ST_FL_WB: if (can_emit) state_d = ST_FL_CHK;
      ST_ONE:   if (can_emit) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs: handshake, tag RAM port, result, flag strobes
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o  = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = ent_q;
    wr_en       = 1'b0;
    em_vld      = 1'b0;
    em_kind     = RK_DONE;
    em_idx      = 4'(ent_q);
    em_blk      = blk_q;
    em_hit      = 1'b0;
    em_last     = 1'b0;
    a_claim     = 1'b0;
    a_fill      = 1'b0;
    a_mark_done = 1'b0;
    a_handback  = 1'b0;
    a_flush     = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_SCAN: begin
        // issue the next tag read unless the walk is over
        if (!hit_now && pos_q != NumEnt) begin
          rd_en   = 1'b1;
          rd_addr = list_q[pos_q[IdxW-1:0]];
        end
      end
      ST_DECIDE: a_claim = hit_found_q && !busy_q[ent_q];
      ST_BUSY: begin
        em_vld  = can_emit;
        em_kind = RK_BUSY;
        em_idx  = hit_found_q ? 4'(ent_q) : 4'd0;
        em_hit  = hit_found_q;
        em_last = 1'b1;
      end
      ST_VRD: rd_en = 1'b1;
      ST_WB: begin
        // write back the dirty victim under its old tag
        em_vld  = can_emit;
        em_kind = RK_DISK_WRITE;
        em_blk  = tag_rdata;
      end
      ST_FILL: begin
        wr_en  = 1'b1;
        a_fill = 1'b1;
      end
      ST_RDCHK: begin
        if (need_rd) begin
          em_vld      = can_emit;
          em_kind     = RK_DISK_READ;
          em_hit      = hit_found_q;
          a_mark_done = can_emit;
        end
      end
      ST_DONE: begin
        em_vld  = can_emit;
        em_hit  = hit_found_q;
        em_last = 1'b1;
      end
      ST_HB: begin
        if (!bi_oor && valid_q[bi_idx]) begin
          rd_en   = 1'b1;
          rd_addr = bi_idx;
        end
      end
      ST_HTAG: begin
        if (op_q == OP_WRITE) begin
          em_vld  = can_emit;
          em_kind = RK_DISK_WRITE;
          em_idx  = bi4_q;
          em_blk  = tag_rdata;
        end
      end
      ST_HDONE: begin
        em_vld     = can_emit;
        em_idx     = bi4_q;
        em_blk     = valid_q[bi_idx] ? tag_rdata : '0;
        em_last    = 1'b1;
        a_handback = can_emit;
      end
      ST_FL_CHK: begin
        if (step_q != NumEnt && fl_dirty) begin
          rd_en   = 1'b1;
          rd_addr = fl_ent;
        end
      end
      ST_FL_WB: begin
        em_vld  = can_emit;
        em_kind = RK_DISK_WRITE;
        em_blk  = tag_rdata;
        a_flush = can_emit;
      end
      ST_ONE: begin
        // out-of-range hand back keeps its index; flush and unknown codes report zero
        em_vld  = can_emit;
        em_idx  = (op_q == OP_RELEASE || op_q == OP_DWRITE || op_q == OP_WRITE) ?
                  bi4_q : 4'd0;
        em_blk  = '0;
        em_last = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_GET;
      pos_q       <= '0;
      step_q      <= '0;
      fpos_q      <= '0;
      cmp_vld_q   <= 1'b0;
      hit_found_q <= 1'b0;
      vic_found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q        <= op_e'(operation_i);
            pos_q       <= '0;
            step_q      <= '0;
            fpos_q      <= '0;
            cmp_vld_q   <= 1'b0;
            hit_found_q <= 1'b0;
            vic_found_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          cmp_vld_q <= rd_en;
          if (rd_en) begin
            pos_q <= pos_q + CntW'(1);
            // first free entry in list order is the victim
            if (!vic_found_q && !busy_q[rd_addr]) vic_found_q <= 1'b1;
          end
          if (state_d == ST_DECIDE) hit_found_q <= hit_now;
        end
        ST_FL_CHK: begin
          // a clean entry stays put; the walk pointer steps past it
          if (step_q != NumEnt && !fl_dirty) begin
            fpos_q <= fpos_q + CntW'(1);
            step_q <= step_q + CntW'(1);
          end
        end
        ST_FL_WB: begin
          // flushed entry moves to the tail, so the pointer already sees the next one
          if (a_flush) step_q <= step_q + CntW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      blk_q <= TagW'(block_number_i);
      bi4_q <= buffer_index_i;
    end
    if (state_q == ST_SCAN) begin
      if (rd_en) begin
        cmp_ent_q <= rd_addr;
        if (!vic_found_q && !busy_q[rd_addr]) vic_q <= rd_addr;
      end
      if (state_d == ST_DECIDE) ent_q <= hit_now ? cmp_ent_q : vic_q;
    end
    if (state_q == ST_FL_CHK && step_q != NumEnt && fl_dirty) ent_q <= fl_ent;
  end

  // ---------------------------------------------------------------------------
  // Entry flags and list order
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      busy_q  <= '0;
      done_q  <= '0;
      dirty_q <= '0;
    end else begin
      if (a_claim) busy_q[ent_q] <= 1'b1;
      if (a_fill) begin
        valid_q[ent_q] <= 1'b1;
        busy_q[ent_q]  <= 1'b1;
        done_q[ent_q]  <= 1'b0;
        dirty_q[ent_q] <= 1'b0;
      end
      if (a_mark_done) done_q[ent_q] <= 1'b1;
      if (a_handback) begin
        if (valid_q[bi_idx] && op_q == OP_DWRITE) begin
          dirty_q[bi_idx] <= 1'b1;
          done_q[bi_idx]  <= 1'b1;
        end
        if (valid_q[bi_idx] && op_q == OP_WRITE) begin
          dirty_q[bi_idx] <= 1'b0;
          done_q[bi_idx]  <= 1'b0;
        end
        busy_q[bi_idx] <= 1'b0;
      end
      if (a_flush) begin
        dirty_q[ent_q] <= 1'b0;
        done_q[ent_q]  <= 1'b0;
        busy_q[ent_q]  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        list_q[i] <= IdxW'(ENTRIES - 1 - i);
      end
    end else if (a_flush) begin
      // slots from the flushed one onward shift toward the head
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if (CntW'(i) >= fpos_q) list_q[i] <= list_q[i+1];
      end
      list_q[ENTRIES-1] <= ent_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (em_vld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_vld) begin
      kind_oq <= em_kind;
      eidx_oq <= em_idx;
      dblk_oq <= 24'(em_blk);
      hit_oq  <= em_hit;
      last_oq <= em_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reply_kind_o  = kind_oq;
  assign entry_index_o = eidx_oq;
  assign disk_block_o  = dblk_oq;
  assign was_hit_o     = hit_oq;
  assign last_o        = last_oq;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_flags_need_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((busy_q | done_q | dirty_q) & ~valid_q) == '0)
    else $error("flag set on an entry that was never filled");

  a_flush_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fpos_q <= step_q) && (step_q <= NumEnt))
    else $error("flush walk pointer ran ahead of its step count");

  a_flush_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FL_WB) |-> (valid_q[ent_q] && dirty_q[ent_q]))
    else $error("flush writing back a clean entry");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("accepted transaction was not started");

endmodule

`default_nettype wire

### tb/tb_block_buffer_cache_controller.sv
// Self-checking testbench for the block buffer cache controller: directed table, random traffic.

module tb_block_buffer_cache_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int ENTRIES = 16;
  localparam int POOL_SIZE = 24;
  // Operation codes outside op_e: the block must answer them with a bare done reply.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // One result transaction as seen on the output port.
  typedef struct packed {
    reply_kind_e kind;
    logic [3:0]  entry;
    logic [23:0] blk;
    logic        hit;
    logic        last;
  } reply_t;

  // One row of the directed table. A pinned row carries its final reply typed in by hand.
  typedef struct packed {
    logic [2:0]  op;
    logic [23:0] blk;
    logic [3:0]  idx;
    logic [4:0]  reps;
    logic        pinned;
    reply_t      final_reply;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  operation_i = OP_GET;
  logic [23:0] block_number_i = '0;
  logic [3:0]  buffer_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  reply_kind_e reply_kind_o;
  logic [3:0]  entry_index_o;
  logic [23:0] disk_block_o;
  logic        was_hit_o;
  logic        last_o;

  always #4 clk_i = ~clk_i;

  block_buffer_cache_controller #(
    .ENTRIES    (ENTRIES),
    .BLOCK_BITS (24)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .block_number_i (block_number_i),
    .buffer_index_i (buffer_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .reply_kind_o   (reply_kind_o),
    .entry_index_o  (entry_index_o),
    .disk_block_o   (disk_block_o),
    .was_hit_o      (was_hit_o),
    .last_o         (last_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the cache: tags, per-entry flags and the free-list order (head first).
  // Updated at the edge where a request transaction is accepted; since the block keeps
  // only one request in flight, its replies come out in the same order.
  // ---------------------------------------------------------------------------
  logic [23:0]        cache_tag [ENTRIES];
  logic [3:0]         chain_order [ENTRIES];
  bit [ENTRIES-1:0]   cache_valid, cache_busy, cache_done, cache_dirty;
  reply_t             pending_replies_q [$];

  int mismatch_count = 0;
  int replies_checked = 0;
  int requests_sent = 0;
  int directed_count = 0;
  int disk_writes_seen = 0, disk_reads_seen = 0, busy_seen = 0;

  // Idle knobs, in percent of cycles, changed per phase by the sequencer.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  // Long receiver hold-offs: asked by the sequencer, counted out by the receiver process.
  int holds_asked = 0, holds_served = 0, hold_left = 0;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on reply %0d, %s: got %0h, expected %0h",
             $realtime, replies_checked, what, got, want);
  endtask

  task automatic push_reply(input reply_kind_e kind, input int entry, input logic [23:0] blk,
                            input logic hit, input logic last);
    reply_t r;
    r.kind  = kind;
    r.entry = entry[3:0];
    r.blk   = blk;
    r.hit   = hit;
    r.last  = last;
    pending_replies_q.push_back(r);
  endtask

  task automatic clear_cache_shadow();
    for (int e = 0; e < ENTRIES; e++) begin
      cache_tag[e]   = '0;
      chain_order[e] = 4'(ENTRIES - 1 - e);
    end
    cache_valid = '0;
    cache_busy  = '0;
    cache_done  = '0;
    cache_dirty = '0;
  endtask

  // Get and read: hit on a cached block, or claim the first free entry in list order.
  task automatic claim_block(input bit is_read, input logic [23:0] blk);
    int  slot;
    bit  found;
    bit  hit;
    slot  = 0;
    found = 0;
    hit   = 0;
    for (int p = 0; p < ENTRIES; p++) begin
      if (!found && cache_valid[chain_order[p]] && cache_tag[chain_order[p]] == blk) begin
        slot  = chain_order[p];
        found = 1;
      end
    end
    if (found) begin
      if (cache_busy[slot]) begin
        push_reply(RK_BUSY, slot, blk, 1'b1, 1'b1);
        return;
      end
      cache_busy[slot] = 1'b1;
      hit = 1;
    end else begin
      for (int p = 0; p < ENTRIES; p++) begin
        if (!found && !cache_busy[chain_order[p]]) begin
          slot  = chain_order[p];
          found = 1;
        end
      end
      // every entry held: retry reply, nothing changes
      if (!found) begin
        push_reply(RK_BUSY, 0, blk, 1'b0, 1'b1);
        return;
      end
      // dirty victim goes back to disk under its old tag first
      if (cache_valid[slot] && cache_dirty[slot])
        push_reply(RK_DISK_WRITE, slot, cache_tag[slot], 1'b0, 1'b0);
      cache_tag[slot]   = blk;
      cache_valid[slot] = 1'b1;
      cache_busy[slot]  = 1'b1;
      cache_done[slot]  = 1'b0;
      cache_dirty[slot] = 1'b0;
    end
    if (is_read && !cache_done[slot]) begin
      push_reply(RK_DISK_READ, slot, blk, hit, 1'b0);
      cache_done[slot] = 1'b1;
    end
    push_reply(RK_DONE, slot, blk, hit, 1'b1);
  endtask

  // Flush: walk a snapshot of the list, write each dirty entry and move it to the tail.
  task automatic flush_dirty();
    logic [3:0] snap [ENTRIES];
    int         e;
    int         pos;
    for (int p = 0; p < ENTRIES; p++) snap[p] = chain_order[p];
    for (int p = 0; p < ENTRIES; p++) begin
      e = snap[p];
      if (cache_valid[e] && cache_dirty[e]) begin
        push_reply(RK_DISK_WRITE, e, cache_tag[e], 1'b0, 1'b0);
        cache_dirty[e] = 1'b0;
        cache_done[e]  = 1'b0;
        cache_busy[e]  = 1'b0;
        pos = 0;
        while (chain_order[pos] != e) pos++;
        for (int q = pos; q < ENTRIES - 1; q++) chain_order[q] = chain_order[q + 1];
        chain_order[ENTRIES - 1] = e[3:0];
      end
    end
    push_reply(RK_DONE, 0, '0, 1'b0, 1'b1);
  endtask

  // Release, delayed write and write hand an entry back to the cache.
  task automatic hand_back(input logic [2:0] op, input logic [3:0] idx);
    if (op == OP_DWRITE && cache_valid[idx]) begin
      cache_dirty[idx] = 1'b1;
      cache_done[idx]  = 1'b1;
    end
    if (op == OP_WRITE && cache_valid[idx]) begin
      push_reply(RK_DISK_WRITE, idx, cache_tag[idx], 1'b0, 1'b0);
      cache_done[idx]  = 1'b0;
      cache_dirty[idx] = 1'b0;
    end
    cache_busy[idx] = 1'b0;
    // an entry never tagged reports block zero, so its tag is never read
    push_reply(RK_DONE, idx, cache_valid[idx] ? cache_tag[idx] : 24'd0, 1'b0, 1'b1);
  endtask

  task automatic predict_request(input logic [2:0] op, input logic [23:0] blk,
                                 input logic [3:0] idx);
    case (op)
      OP_GET:                        claim_block(1'b0, blk);
      OP_READ:                       claim_block(1'b1, blk);
      OP_RELEASE, OP_DWRITE, OP_WRITE: hand_back(op, idx);
      OP_FLUSH:                      flush_dirty();
      default:                       push_reply(RK_DONE, 0, '0, 1'b0, 1'b1);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request side. Called right after a falling edge; returns at the falling edge after the
  // transaction was accepted, with valid still high, so the caller either sends the next
  // request in that step or lowers valid itself.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [2:0] op, input logic [23:0] blk,
                              input logic [3:0] idx, input bit pinned,
                              input reply_t final_reply);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    block_number_i <= blk;
    buffer_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(op, blk, idx);
    // hand-typed final reply replaces the predicted one for pinned table rows
    if (pinned) pending_replies_q[pending_replies_q.size() - 1] = final_reply;
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Sender goes quiet until every expected reply has arrived.
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (pending_replies_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready toggles at the falling edge, long hold-offs on request.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left    = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Every accepted reply is checked field by field against the oldest expectation.
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies_q.size() == 0) begin
        note_mismatch("unexpected reply, kind", 32'(reply_kind_o), 32'hFFFF_FFFF);
      end else begin
        want = pending_replies_q.pop_front();
        if (reply_kind_o !== want.kind)
          note_mismatch("reply_kind", 32'(reply_kind_o), 32'(want.kind));
        if (entry_index_o !== want.entry)
          note_mismatch("entry_index", 32'(entry_index_o), 32'(want.entry));
        if (disk_block_o !== want.blk)
          note_mismatch("disk_block", 32'(disk_block_o), 32'(want.blk));
        if (was_hit_o !== want.hit)
          note_mismatch("was_hit", 32'(was_hit_o), 32'(want.hit));
        if (last_o !== want.last)
          note_mismatch("last", 32'(last_o), 32'(want.last));
        case (want.kind)
          RK_DISK_WRITE: disk_writes_seen++;
          RK_DISK_READ:  disk_reads_seen++;
          RK_BUSY:       busy_seen++;
          default:       ;
        endcase
      end
      replies_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [$];

  task automatic add_row(input logic [2:0] op, input logic [23:0] blk, input logic [3:0] idx,
                         input int reps, input bit pinned, input reply_kind_e kind,
                         input logic [3:0] entry, input logic [23:0] dblk, input logic hit);
    stim_row_t row;
    row.op                = op;
    row.blk               = blk;
    row.idx               = idx;
    row.reps              = 5'(reps);
    row.pinned            = pinned;
    row.final_reply.kind  = kind;
    row.final_reply.entry = entry;
    row.final_reply.blk   = dblk;
    row.final_reply.hit   = hit;
    row.final_reply.last  = 1'b1;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed_table();
    // after reset the list head is entry 15, then 14
    add_row(OP_GET,     24'h000000, 4'h0, 1, 1, RK_DONE, 4'd15, 24'h000000, 1'b0);
    // miss on a read: disk read, then done on entry 14
    add_row(OP_READ,    24'hFFFFFF, 4'hF, 1, 1, RK_DONE, 4'd14, 24'hFFFFFF, 1'b0);
    // hit on a held entry: retry
    add_row(OP_GET,     24'h000000, 4'h0, 1, 1, RK_BUSY, 4'd15, 24'h000000, 1'b1);
    add_row(OP_DWRITE,  24'h123456, 4'hF, 1, 1, RK_DONE, 4'd15, 24'h000000, 1'b0);
    // hit on a free entry that is already done: no disk read
    add_row(OP_READ,    24'h000000, 4'h0, 1, 1, RK_DONE, 4'd15, 24'h000000, 1'b1);
    add_row(OP_WRITE,   24'h000000, 4'hF, 1, 1, RK_DONE, 4'd15, 24'h000000, 1'b0);
    add_row(OP_DWRITE,  24'h000000, 4'hE, 1, 1, RK_DONE, 4'd14, 24'hFFFFFF, 1'b0);
    // clean victim, then dirty victim written back under its old tag
    add_row(OP_GET,     24'h800000, 4'h0, 1, 0, RK_DONE, 4'd0,  24'h000000, 1'b0);
    add_row(OP_GET,     24'h000001, 4'h0, 1, 0, RK_DONE, 4'd0,  24'h000000, 1'b0);
    add_row(OP_RELEASE, 24'h000000, 4'hE, 1, 1, RK_DONE, 4'd14, 24'h000001, 1'b0);
    add_row(OP_DWRITE,  24'h000000, 4'hF, 1, 1, RK_DONE, 4'd15, 24'h800000, 1'b0);
    add_row(OP_FLUSH,   24'hFFFFFF, 4'hF, 1, 1, RK_DONE, 4'd0,  24'h000000, 1'b0);
    // hand back of entries never tagged
    add_row(OP_RELEASE, 24'h000000, 4'h0, 1, 1, RK_DONE, 4'd0,  24'h000000, 1'b0);
    add_row(OP_WRITE,   24'h000000, 4'h9, 1, 1, RK_DONE, 4'd9,  24'h000000, 1'b0);
    add_row(OP_DWRITE,  24'h000000, 4'h7, 1, 1, RK_DONE, 4'd7,  24'h000000, 1'b0);
    // codes outside the operation set
    add_row(OP_SPARE_LO, 24'h000000, 4'h0, 1, 1, RK_DONE, 4'd0, 24'h000000, 1'b0);
    add_row(OP_SPARE_HI, 24'hFFFFFF, 4'hF, 1, 1, RK_DONE, 4'd0, 24'h000000, 1'b0);
    // hold every entry, then a miss finds nothing free
    add_row(OP_GET,     24'h5A5A5A, 4'h0, ENTRIES, 0, RK_DONE, 4'd0, 24'h000000, 1'b0);
    add_row(OP_GET,     24'hA5A5A5, 4'h0, 1, 1, RK_BUSY, 4'd0,  24'hA5A5A5, 1'b0);
    add_row(OP_READ,    24'h5A5A5A, 4'h0, 1, 0, RK_DONE, 4'd0,  24'h000000, 1'b0);
    add_row(OP_FLUSH,   24'h000000, 4'h0, 1, 1, RK_DONE, 4'd0,  24'h000000, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly well-formed claim / hand-back cycles over a small block pool so
  // that hits, misses, dirty victims and full-cache retries keep occurring.
  // ---------------------------------------------------------------------------
  logic [23:0] block_pool [POOL_SIZE];

  task automatic pick_random(output logic [2:0] op, output logic [23:0] blk,
                             output logic [3:0] idx);
    int r;
    int held [$];
    r   = $urandom_range(99);
    blk = 24'($urandom());
    idx = 4'($urandom_range(ENTRIES - 1));
    if (r < 36) begin
      op = (r < 18) ? OP_GET : OP_READ;
      if ($urandom_range(99) < 5) block_pool[$urandom_range(POOL_SIZE - 1)] = 24'($urandom());
      if ($urandom_range(99) < 85) blk = block_pool[$urandom_range(POOL_SIZE - 1)];
    end else if (r < 80) begin
      case ($urandom_range(2))
        0:       op = OP_RELEASE;
        1:       op = OP_DWRITE;
        default: op = OP_WRITE;
      endcase
      // mostly hand back something actually held
      for (int e = 0; e < ENTRIES; e++) if (cache_busy[e]) held.push_back(e);
      if (held.size() != 0 && $urandom_range(99) < 85)
        idx = 4'(held[$urandom_range(held.size() - 1)]);
    end else if (r < 88) begin
      op = OP_FLUSH;
    end else if (r < 92) begin
      op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
    end else begin
      op = OP_GET;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    logic [2:0]  op;
    logic [23:0] blk;
    logic [3:0]  idx;
    clear_cache_shadow();
    build_directed_table();
    for (int i = 0; i < POOL_SIZE; i++) block_pool[i] = 24'($urandom());
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, no idling on either side
    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        send_request(directed_rows[i].op, directed_rows[i].blk + 24'(k), directed_rows[i].idx,
                     directed_rows[i].pinned, directed_rows[i].final_reply);
      end
    end
    directed_count = requests_sent;
    drain_replies();

    // random phases: none, sender idle, receiver stall, both lightly
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
        default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
      endcase
      for (int n = 0; n < 70; n++) begin
        // long output hold-off while requests keep coming: block fills and stalls its input
        if ((phase == 0 && n == 20) || (phase == 2 && n == 30)) holds_asked++;
        pick_random(op, blk, idx);
        send_request(op, blk, idx, 1'b0, '0);
      end
      drain_replies();
    end

    repeat (40) @(posedge clk_i);
    $display("Sent %0d requests (%0d from the directed table), checked %0d replies:",
             requests_sent, directed_count, replies_checked);
    $display("  %0d disk writes, %0d disk reads, %0d busy retries, %0d mismatches.",
             disk_writes_seen, disk_reads_seen, busy_seen, mismatch_count);
    if (mismatch_count == 0 && pending_replies_q.size() == 0)
      $display("block_buffer_cache_controller regression: pass");
    else
      $display("block_buffer_cache_controller regression: fail");
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d replies still expected.", pending_replies_q.size());
    $display("block_buffer_cache_controller regression: fail");
    $finish;
  end

endmodule
